>>> design/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and codes for the vertex de-duplicating indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

   localparam int unsigned VertexBits = 192;
   localparam int unsigned IndexBits  = 10;
   localparam int unsigned StatusBits = 2;

   localparam logic [StatusBits-1:0] STATUS_REUSED = 2'd0;
   localparam logic [StatusBits-1:0] STATUS_NEW    = 2'd1;
   localparam logic [StatusBits-1:0] STATUS_FULL   = 2'd2;

   typedef logic [VertexBits-1:0] vertex_type;

   typedef struct packed {
      logic [IndexBits-1:0]  vertex_index;
      logic [StatusBits-1:0] status;
   } result_type;

endpackage

>>> design/vdi_ram.sv
// ----------------------------------------------------------------------------
// vdi_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module vdi_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Assigns indices to vertices, reusing the index of an identical one.
// ----------------------------------------------------------------------------
// One vertex beat is handled at a time. The table lives in one RAM with a
// registered read. It is scanned linearly, one entry per cycle, from index
// 0 up to the current fill count. A vertex that matches entry k ends the
// scan there; a vertex that matches nothing (new or full) is answered once
// every filled entry has been compared. The result waits in an output
// register until it is taken, and req_tready stays low meanwhile. The next
// beat is therefore accepted no sooner than the cycle after the response
// beat. The fill count marks the valid entries, so no clearing pass is
// needed after reset or at a mesh start.
module vertex_dedup_indexer #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // start_mesh
   input  logic [191:0] req_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata    // vertex_index[9:0], status[11:10], zero
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        scan_ff, scan_in;     // address issued
   logic [CW-1:0]        cmp_ff, cmp_in;       // index whose data is back
   logic                 cmp_vld_ff, cmp_vld_in;
   vdi_pkg::vertex_type  key_ff;
   vdi_pkg::result_type  res_ff, res_in;
   logic                 rsp_vld_ff, rsp_vld_in;

   logic                 wr_en;
   vdi_pkg::vertex_type  rd_data;
   logic                 accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_vld_ff;

   vdi_ram #(.WIDTH(vdi_pkg::VertexBits), .DEPTH(CAPACITY)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      cmp_in     = cmp_ff;
      cmp_vld_in = 1'b0;
      res_in     = res_ff;
      rsp_vld_in = rsp_vld_ff;
      wr_en      = 1'b0;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  count_in = '0;
               end
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && rd_data == key_ff) begin
               res_in.vertex_index = vdi_pkg::IndexBits'(cmp_ff);
               res_in.status       = vdi_pkg::STATUS_REUSED;
               state_in            = ST_DONE;
            end else if (scan_ff < count_ff) begin
               // issue next read, track its index
               cmp_in     = scan_ff;
               cmp_vld_in = 1'b1;
               scan_in    = scan_ff + 1'b1;
            end else if (!cmp_vld_ff || cmp_ff + 1'b1 == count_ff) begin
               if (count_ff == CapCount) begin
                  res_in.vertex_index = '0;
                  res_in.status       = vdi_pkg::STATUS_FULL;
               end else begin
                  wr_en               = 1'b1;
                  res_in.vertex_index = vdi_pkg::IndexBits'(count_ff);
                  res_in.status       = vdi_pkg::STATUS_NEW;
                  count_in            = count_ff + 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_vld_in = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      cmp_ff  <= cmp_in;
      res_ff  <= res_in;
      if (accept) begin
         key_ff <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0, res_ff.status, res_ff.vertex_index};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount) else $error("fill count beyond capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN) else $error("accept did not start scan");
   a_write_new: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> res_ff.status == vdi_pkg::STATUS_NEW) else $error("write without new status");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_ff <= count_ff) else $error("scan past fill count");

endmodule

>>> test/vertex_dedup_indexer_tb.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_tb
// Self-checking bench for the vertex de-duplicating indexer.
// ----------------------------------------------------------------------------
// A table of directed vertices covers reset state, signed zeros, NaN patterns
// and mesh starts. Random meshes mixing repeats, near-misses and fresh
// vertices follow, with stalls on both sides and one long receiver hold-off.
// One mesh is then filled to capacity to reach the full status. Every
// response beat is checked against a local model of the index table.
module vertex_dedup_indexer_tb;

   localparam int unsigned TableDepth  = 1024;
   localparam int unsigned CycleLimit  = 3000000;
   localparam int unsigned RandomItems = 540;
   localparam int unsigned FillItems   = TableDepth + 3;
   localparam int unsigned RowCount    = 15;

   typedef struct {
      logic                start;
      vdi_pkg::vertex_type vtx;
      bit                  typed;
      logic [9:0]          idx;
      logic [1:0]          st;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser = 1'b0;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;

   vdi_pkg::vertex_type seen_table [TableDepth];
   int unsigned         seen_count = 0;
   vdi_pkg::result_type pending_results [$];
   int unsigned         errors = 0;
   int unsigned         cycles = 0;
   int unsigned         stat_hits [3] = '{0, 0, 0};
   int unsigned         beats_sent = 0;
   bit                  quiet = 1'b0;
   bit                  long_hold_req = 1'b0;
   int unsigned         hold_cnt = 0;
   row_type             rows [RowCount];

   vertex_dedup_indexer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("%0t timeout after %0d cycles", $time, cycles);
         $display("vertex_dedup_indexer_tb: done, errors");
         $finish;
      end
   end

   // Look the vertex up, store it if new, and return the expected response.
   function automatic vdi_pkg::result_type index_vertex(input logic start,
                                                        input vdi_pkg::vertex_type vtx);
      vdi_pkg::result_type r;
      if (start) seen_count = 0;
      for (int unsigned k = 0; k < seen_count; k++) begin
         if (seen_table[k] === vtx) begin
            r.vertex_index = k[9:0];
            r.status = vdi_pkg::STATUS_REUSED;
            return r;
         end
      end
      if (seen_count >= TableDepth) begin
         r.vertex_index = '0;
         r.status = vdi_pkg::STATUS_FULL;
         return r;
      end
      seen_table[seen_count] = vtx;
      r.vertex_index = seen_count[9:0];
      r.status = vdi_pkg::STATUS_NEW;
      seen_count++;
      return r;
   endfunction

   // Fields from the lowest bits up: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z.
   function automatic vdi_pkg::vertex_type mk_vtx(input logic [31:0] px, input logic [31:0] py,
                                                  input logic [31:0] pz, input logic [31:0] nx,
                                                  input logic [31:0] ny, input logic [31:0] nz);
      return {nz, ny, nx, pz, py, px};
   endfunction

   function automatic vdi_pkg::vertex_type fill_vtx(input int unsigned n);
      return {32'h3f80_0000, 128'h0, n[31:0]};
   endfunction

   function automatic row_type mk_row(input logic start, input vdi_pkg::vertex_type vtx,
                                      input bit typed, input logic [9:0] idx,
                                      input logic [1:0] st);
      row_type r;
      r.start = start;
      r.vtx   = vtx;
      r.typed = typed;
      r.idx   = idx;
      r.st    = st;
      return r;
   endfunction

   // Offer one beat, hold it until accepted, and queue its expected response.
   task automatic send(input logic start, input vdi_pkg::vertex_type vtx, input bit typed,
                       input logic [9:0] idx, input logic [1:0] st);
      vdi_pkg::result_type want;
      int unsigned         gap;
      want = index_vertex(start, vtx);
      if (typed) begin
         want.vertex_index = idx;
         want.status       = st;
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= vtx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(want);
      beats_sent++;
   endtask

   // Response side: check each beat, stall in bursts, one long hold-off.
   always @(posedge clock) begin
      vdi_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected beat: expected none, actual idx %0d status %0d",
                        $time, rsp_tdata[9:0], rsp_tdata[11:10]);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[9:0] !== want.vertex_index) begin
                  $display("%0t vertex_index: expected %0d, actual %0d",
                           $time, want.vertex_index, rsp_tdata[9:0]);
                  errors++;
               end
               if (rsp_tdata[11:10] !== want.status) begin
                  $display("%0t status: expected %0d, actual %0d",
                           $time, want.status, rsp_tdata[11:10]);
                  errors++;
               end
               if (rsp_tdata[15:12] !== 4'd0) begin
                  $display("%0t pad bits: expected 0, actual %h", $time, rsp_tdata[15:12]);
                  errors++;
               end
               if (want.status <= vdi_pkg::STATUS_FULL) stat_hits[int'(want.status)]++;
            end
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cnt = 300;
            rsp_tready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_cnt = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      vdi_pkg::vertex_type vta, vtb, vtz, vtnz, vtn1, vtn2, vt1s, vtbx, vtx;
      vdi_pkg::vertex_type mesh_list [$];
      logic                start;
      int unsigned         kind;
      int unsigned         bitpos;

      vta  = mk_vtx(32'h3f80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0, 32'h0, 32'h3f80_0000);
      vtb  = mk_vtx(32'hbf80_0000, 32'h3f00_0000, 32'h0, 32'h3f80_0000, 32'h0, 32'h0);
      vtz  = '0;
      vtnz = mk_vtx(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      vtn1 = {6{32'h7fc0_0000}};
      vtn2 = {32'h7fc0_0001, {5{32'h7fc0_0000}}};
      vt1s = '1;
      vtbx = vtb;
      vtbx[160] = ~vtbx[160];

      rows[0]  = mk_row(1'b0, vta,  1'b1, 10'd0, vdi_pkg::STATUS_NEW);
      rows[1]  = mk_row(1'b0, vta,  1'b1, 10'd0, vdi_pkg::STATUS_REUSED);
      rows[2]  = mk_row(1'b0, vtz,  1'b1, 10'd1, vdi_pkg::STATUS_NEW);
      rows[3]  = mk_row(1'b0, vtnz, 1'b1, 10'd2, vdi_pkg::STATUS_NEW);
      rows[4]  = mk_row(1'b0, vtz,  1'b1, 10'd1, vdi_pkg::STATUS_REUSED);
      rows[5]  = mk_row(1'b0, vtn1, 1'b1, 10'd3, vdi_pkg::STATUS_NEW);
      rows[6]  = mk_row(1'b0, vtn2, 1'b1, 10'd4, vdi_pkg::STATUS_NEW);
      rows[7]  = mk_row(1'b0, vtn1, 1'b1, 10'd3, vdi_pkg::STATUS_REUSED);
      rows[8]  = mk_row(1'b0, vt1s, 1'b0, 10'd0, vdi_pkg::STATUS_REUSED);
      rows[9]  = mk_row(1'b1, vta,  1'b1, 10'd0, vdi_pkg::STATUS_NEW);
      rows[10] = mk_row(1'b1, vtb,  1'b1, 10'd0, vdi_pkg::STATUS_NEW);
      rows[11] = mk_row(1'b0, vta,  1'b0, 10'd0, vdi_pkg::STATUS_REUSED);
      rows[12] = mk_row(1'b0, vtbx, 1'b0, 10'd0, vdi_pkg::STATUS_REUSED);
      rows[13] = mk_row(1'b0, vtb,  1'b0, 10'd0, vdi_pkg::STATUS_REUSED);
      rows[14] = mk_row(1'b1, vtz,  1'b1, 10'd0, vdi_pkg::STATUS_NEW);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned i = 0; i < RowCount; i++) begin
         send(rows[i].start, rows[i].vtx, rows[i].typed, rows[i].idx, rows[i].st);
      end

      for (int unsigned i = 0; i < RandomItems; i++) begin
         start = (mesh_list.size() == 0) || (mesh_list.size() >= 64) ||
                 ($urandom_range(0, 39) == 0);
         if (start) mesh_list.delete();
         kind = $urandom_range(0, 9);
         if (mesh_list.size() > 0 && kind < 4) begin
            vtx = mesh_list[$urandom_range(0, mesh_list.size() - 1)];
         end else if (mesh_list.size() > 0 && kind < 6) begin
            vtx = mesh_list[$urandom_range(0, mesh_list.size() - 1)];
            bitpos = $urandom_range(0, 191);
            vtx[bitpos] = ~vtx[bitpos];
         end else if (kind < 7) begin
            vtx = '0;
            for (int unsigned w = 0; w < 6; w++) begin
               vtx[w * 32 + 31] = 1'($urandom_range(0, 1));
            end
         end else begin
            vtx = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         end
         mesh_list.push_back(vtx);
         if (i == RandomItems / 2) long_hold_req = 1'b1;
         send(start, vtx, 1'b0, 10'd0, vdi_pkg::STATUS_REUSED);
      end

      // Fill one mesh past capacity with no idling on either side.
      quiet = 1'b1;
      for (int unsigned n = 0; n < FillItems; n++) begin
         send(n == 0, fill_vtx(n), 1'b0, 10'd0, vdi_pkg::STATUS_REUSED);
      end
      send(1'b0, fill_vtx(5), 1'b1, 10'd5, vdi_pkg::STATUS_REUSED);
      send(1'b0, fill_vtx(TableDepth - 1), 1'b1, 10'd1023, vdi_pkg::STATUS_REUSED);
      send(1'b0, fill_vtx(TableDepth), 1'b1, 10'd0, vdi_pkg::STATUS_FULL);
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d beats: %0d reused, %0d new, %0d full", beats_sent,
               stat_hits[0], stat_hits[1], stat_hits[2]);
      $display("signed zeros, NaN patterns, mesh starts, stalls and a full table exercised");
      if (errors == 0) begin
         $display("vertex_dedup_indexer_tb: done, clean");
      end else begin
         $display("vertex_dedup_indexer_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
design/vdi_pkg.sv
design/vdi_ram.sv
design/vertex_dedup_indexer.sv
test/vertex_dedup_indexer_tb.sv
